/* src/hbse_pkg.sv */
`default_nettype none

package hbse_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned NUM_CHECKS = 6;

  // Length of the code word for a block of nbits data bits.
  function automatic int unsigned code_len(input int unsigned nbits);
    int unsigned len;
    len = nbits;
    for (int unsigned i = 0; i < NUM_CHECKS; i++) begin
      if ((32'd1 << i) <= len) begin
        len++;
      end
    end
    return len;
  endfunction

  function automatic bit is_check(input int unsigned k);
    return (k != 0) && ((k & (k - 1)) == 0);
  endfunction

  // Data bit that lands at a non-check position of the code word.
  function automatic int unsigned data_index(input int unsigned k);
    int unsigned n;
    n = 0;
    for (int unsigned i = 0; i < NUM_CHECKS; i++) begin
      if ((32'd1 << i) <= k) begin
        n++;
      end
    end
    return k - n;
  endfunction

endpackage

`default_nettype wire

/* src/hbse_front.sv */
`default_nettype none

module hbse_front #(
  parameter int unsigned BLOCK_BYTES = 7,
  parameter int unsigned CW          = 62,
  parameter int unsigned LEN_W       = 6
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  wire logic [7:0]       s_axis_tdata_i,
  input  wire logic             s_axis_tlast_i,
  input  wire logic             q_full_i,
  output logic                  push_o,
  output logic [CW-1:0]         word_o,
  output logic [LEN_W-1:0]      len_o,
  output logic                  eos_o
);
  import hbse_pkg::*;

  localparam int unsigned DW   = BYTE_W * BLOCK_BYTES;
  localparam int unsigned NB_W = $clog2(BLOCK_BYTES + 1);
  localparam int unsigned DI_W = $clog2(DW);

  logic [DW-1:0]   block_q, block_d;
  logic [NB_W-1:0] nbytes_q, nbytes_d;
  logic [DW-1:0]   merged;
  logic [NB_W-1:0] nb_next;
  logic            accept;
  logic            complete;

  for (genvar j = 0; j < BLOCK_BYTES; j++) begin : g_lane
    assign merged[BYTE_W*j +: BYTE_W] = (nbytes_q == NB_W'(j)) ? s_axis_tdata_i
                                                               : block_q[BYTE_W*j +: BYTE_W];
  end

  for (genvar k = 0; k < CW; k++) begin : g_map
    if (is_check(k)) begin : g_par
      logic par;
      always_comb begin
        par = 1'b0;
        for (int unsigned j = 0; j < CW; j++) begin
          if (((j & k) != 0) && !is_check(j)) begin
            par = par ^ merged[DI_W'(data_index(j))];
          end
        end
      end
      assign word_o[k] = par;
    end else begin : g_dat
      assign word_o[k] = merged[DI_W'(data_index(k))];
    end
  end

  always_comb begin
    s_axis_tready_o = !q_full_i;
    accept          = s_axis_tvalid_i && s_axis_tready_o;
    nb_next         = nbytes_q + NB_W'(1);
    complete        = (nb_next == NB_W'(BLOCK_BYTES)) || s_axis_tlast_i;
    push_o          = accept && complete;
    len_o           = LEN_W'(code_len(BYTE_W * 32'(nb_next)));
    eos_o           = s_axis_tlast_i;
    block_d         = block_q;
    nbytes_d        = nbytes_q;
    if (accept) begin
      if (complete) begin
        block_d  = '0;
        nbytes_d = '0;
      end else begin
        block_d  = merged;
        nbytes_d = nb_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_q  <= '0;
      nbytes_q <= '0;
    end else begin
      block_q  <= block_d;
      nbytes_q <= nbytes_d;
    end
  end

endmodule

`default_nettype wire

/* src/hbse_fifo.sv */
`default_nettype none

module hbse_fifo #(
  parameter int unsigned WIDTH = 69
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  output logic                  valid_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      rdata_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q;
  logic             rd_ptr_q;
  logic [1:0]       count_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

/* src/hbse_back.sv */
`default_nettype none

module hbse_back #(
  parameter int unsigned CW    = 62,
  parameter int unsigned LEN_W = 6
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             job_valid_i,
  input  wire logic [CW-1:0]    job_word_i,
  input  wire logic [LEN_W-1:0] job_len_i,
  input  wire logic             job_eos_i,
  output logic                  job_pop_o,
  output logic                  m_axis_tvalid_o,
  input  wire logic             m_axis_tready_i,
  output logic [7:0]            m_axis_tdata_o,
  output logic                  m_axis_tlast_o,
  output logic                  m_axis_tuser_o
);
  import hbse_pkg::*;

  localparam int unsigned CB_W  = CW + BYTE_W;
  localparam int unsigned CNT_W = $clog2(CW + BYTE_W);

  logic [CW-1:0]    buf_q, buf_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             flush_q, flush_d;
  logic             valid_q, valid_d;
  logic [7:0]       data_q, data_d;
  logic             last_q, last_d;
  logic             done_q, done_d;
  logic             adv;
  logic             cnt_lo;
  logic [CB_W-1:0]  comb;
  logic [CNT_W-1:0] ccnt;

  always_comb begin
    adv       = !valid_q || m_axis_tready_i;
    cnt_lo    = cnt_q < CNT_W'(BYTE_W);
    comb      = CB_W'(buf_q) | (CB_W'(job_word_i) << cnt_q[2:0]);
    ccnt      = cnt_q + CNT_W'(job_len_i);
    buf_d     = buf_q;
    cnt_d     = cnt_q;
    flush_d   = flush_q;
    data_d    = data_q;
    last_d    = last_q;
    done_d    = done_q;
    job_pop_o = 1'b0;
    valid_d   = valid_q && !m_axis_tready_i;
    if (adv) begin
      if (!cnt_lo) begin
        valid_d = 1'b1;
        data_d  = buf_q[7:0];
        buf_d   = buf_q >> BYTE_W;
        cnt_d   = cnt_q - CNT_W'(BYTE_W);
        last_d  = (cnt_d < CNT_W'(BYTE_W)) && (!flush_q || (cnt_d == '0));
        done_d  = last_d && flush_q;
        if (done_d) begin
          flush_d = 1'b0;
        end
      end else if (flush_q) begin
        valid_d = 1'b1;
        data_d  = buf_q[7:0];
        buf_d   = '0;
        cnt_d   = '0;
        last_d  = 1'b1;
        done_d  = 1'b1;
        flush_d = 1'b0;
      end else if (job_valid_i) begin
        job_pop_o = 1'b1;
        valid_d   = 1'b1;
        data_d    = comb[7:0];
        buf_d     = CW'(comb >> BYTE_W);
        cnt_d     = ccnt - CNT_W'(BYTE_W);
        last_d    = (cnt_d < CNT_W'(BYTE_W)) && (!job_eos_i || (cnt_d == '0));
        done_d    = last_d && job_eos_i;
        flush_d   = job_eos_i && !last_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q   <= '0;
      cnt_q   <= '0;
      flush_q <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      buf_q   <= buf_d;
      cnt_q   <= cnt_d;
      flush_q <= flush_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    last_q <= last_d;
    done_q <= done_d;
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = data_q;
  assign m_axis_tlast_o  = last_q;
  assign m_axis_tuser_o  = done_q;

endmodule

`default_nettype wire

/* src/hamming_block_stream_encoder.sv */
`default_nettype none

// Hamming encoder for a byte stream. Input bytes are gathered LSB first into
// blocks of DATA_BITS/8 bytes; each full block, and the partial block closed by
// a beat with tlast set, becomes one Hamming code word (62 bits for a 56-bit
// block), and the code words are packed LSB first into output bytes, the last
// byte zero-padded. Output tlast marks the final byte caused by an input beat
// and tuser the final byte of the stream. An input beat is taken in any cycle
// in which the two-entry code word queue has room. The packer sends one byte
// per cycle while the output is ready, so the sustained input rate is set by
// the output: a full 56-bit block gives 62 code bits, seven or eight output
// bytes for seven input bytes, plus any padded byte at the end of a stream. A
// code word passes through the code word queue and the output byte register
// before its first byte is sent.
module hamming_block_stream_encoder #(
  parameter int unsigned DATA_BITS = 56
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // data_byte[7:0]
  input  wire logic       s_axis_tlast_i,
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,   // code_byte[7:0]
  output logic            m_axis_tlast_o,
  output logic            m_axis_tuser_o    // stream_done
);
  import hbse_pkg::*;

  localparam int unsigned BLOCK_BYTES = DATA_BITS / 8;
  localparam int unsigned CW          = code_len(BYTE_W * BLOCK_BYTES);
  localparam int unsigned LEN_W       = $clog2(CW + 1);
  localparam int unsigned JOB_W       = CW + LEN_W + 1;

  logic             q_full;
  logic             push;
  logic [CW-1:0]    word;
  logic [LEN_W-1:0] len;
  logic             eos;
  logic             job_valid;
  logic             job_pop;
  logic [JOB_W-1:0] job;

  hbse_front #(
    .BLOCK_BYTES (BLOCK_BYTES),
    .CW          (CW),
    .LEN_W       (LEN_W)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .q_full_i        (q_full),
    .push_o          (push),
    .word_o          (word),
    .len_o           (len),
    .eos_o           (eos)
  );

  hbse_fifo #(
    .WIDTH (JOB_W)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i ({eos, len, word}),
    .full_o  (q_full),
    .valid_o (job_valid),
    .pop_i   (job_pop),
    .rdata_o (job)
  );

  hbse_back #(
    .CW    (CW),
    .LEN_W (LEN_W)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_valid_i     (job_valid),
    .job_word_i      (job[CW-1:0]),
    .job_len_i       (job[CW +: LEN_W]),
    .job_eos_i       (job[JOB_W-1]),
    .job_pop_o       (job_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

`default_nettype wire

/* src/hbse_checker.sv */
`default_nettype none

module hbse_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       m_axis_tvalid_o,
  input wire logic       m_axis_tready_i,
  input wire logic [7:0] m_axis_tdata_o,
  input wire logic       m_axis_tlast_o,
  input wire logic       m_axis_tuser_o
);

  a_valid_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("Output beat dropped while stalled.");

  a_data_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("Output data changed while stalled.");

  a_done_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tlast_o)
    else $error("End of stream beat is not the last beat of its input.");

  a_reset_idle : assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid_o)
    else $error("Output valid after reset.");

endmodule

bind hamming_block_stream_encoder hbse_checker u_hbse_checker (.*);

`default_nettype wire

/* test/hamming_block_stream_encoder_test.sv */
`default_nettype none

module hamming_block_stream_encoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BLOCK_BYTES = 56 / 8;
  localparam int unsigned NUM_ITEMS   = 252;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } raw_byte_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       run_last;
    logic       stream_done;
  } code_beat_t;

  logic       clk_i           = 1'b0;
  logic       rst_ni          = 1'b0;
  logic       s_axis_tvalid_i = 1'b0;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i  = 8'h00;
  logic       s_axis_tlast_i  = 1'b0;
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i = 1'b0;
  logic [7:0] m_axis_tdata_o;
  logic       m_axis_tlast_o;
  logic       m_axis_tuser_o;

  hamming_block_stream_encoder DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  raw_byte_t  raw_bytes_q[$];
  code_beat_t expected_code_q[$];
  code_beat_t step_beats[$];

  logic [55:0] blk_bits  = '0;
  int unsigned blk_bytes = 0;
  logic [7:0]  pend_bits = '0;
  int unsigned pend_cnt  = 0;

  int unsigned total_items   = 0;
  int unsigned stream_count  = 0;
  int unsigned in_count      = 0;
  int unsigned code_count    = 0;
  int unsigned error_count   = 0;
  logic        in_beat_taken = 1'b0;

  task automatic push_code_byte(input logic [7:0] value);
    code_beat_t beat;
    beat.code_byte   = value;
    beat.run_last    = 1'b0;
    beat.stream_done = 1'b0;
    step_beats = {step_beats, beat};
  endtask

  task automatic encode_block();
    int unsigned len;
    int unsigned p;
    logic [63:0] word;
    logic [63:0] lowpart;
    logic        par;
    len  = blk_bytes * 8;
    word = {8'h00, blk_bits};
    if (len < 56) word = word & ((64'd1 << len) - 64'd1);
    for (int i = 0; i < 6; i++) begin
      p = 1 << i;
      if (p <= len) begin
        lowpart = word & ((64'd1 << p) - 64'd1);
        word    = lowpart | ((word >> p) << (p + 1));
        len++;
      end
    end
    for (int i = 0; i < 6; i++) begin
      p = 1 << i;
      if (p < len) begin
        par = 1'b0;
        for (int unsigned k = 0; k < len; k++) begin
          if ((k & p) != 0) par = par ^ word[k];
        end
        word[p] = par;
      end
    end
    for (int unsigned k = 0; k < len; k++) begin
      pend_bits[pend_cnt] = word[k];
      pend_cnt++;
      if (pend_cnt == 8) begin
        push_code_byte(pend_bits);
        pend_bits = '0;
        pend_cnt  = 0;
      end
    end
    blk_bits  = '0;
    blk_bytes = 0;
  endtask

  task automatic predict_code_bytes(input logic [7:0] data_byte, input logic eos);
    step_beats.delete();
    if (blk_bytes >= BLOCK_BYTES) blk_bytes = 0;
    blk_bits = blk_bits | (56'(data_byte) << (blk_bytes * 8));
    blk_bytes++;
    if (blk_bytes >= BLOCK_BYTES) encode_block();
    if (eos) begin
      if (blk_bytes > 0) encode_block();
      if (pend_cnt > 0) push_code_byte(pend_bits);
      pend_bits = '0;
      pend_cnt  = 0;
      if (step_beats.size() > 0) step_beats[step_beats.size() - 1].stream_done = 1'b1;
    end
    if (step_beats.size() > 0) step_beats[step_beats.size() - 1].run_last = 1'b1;
    foreach (step_beats[i]) expected_code_q = {expected_code_q, step_beats[i]};
  endtask

  function automatic int unsigned send_idle_pct();
    if (in_count < total_items / 3) return 29;
    if (in_count < (2 * total_items) / 3) return 50;
    return 0;
  endfunction

  function automatic int unsigned recv_idle_pct();
    if (in_count < total_items / 3) return 50;
    if (in_count < (2 * total_items) / 3) return 29;
    return 0;
  endfunction

  task automatic queue_byte(input logic [7:0] data_byte, input logic eos);
    raw_byte_t item;
    item.data_byte     = data_byte;
    item.end_of_stream = eos;
    raw_bytes_q = {raw_bytes_q, item};
    total_items++;
    if (eos) stream_count++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      predict_code_bytes(s_axis_tdata_i, s_axis_tlast_i);
      in_count++;
      in_beat_taken <= 1'b1;
    end else begin
      in_beat_taken <= 1'b0;
    end
  end

  always @(negedge clk_i) begin
    raw_byte_t item;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else if (!s_axis_tvalid_i || in_beat_taken) begin
      if (raw_bytes_q.size() > 0 && $urandom_range(99) >= send_idle_pct()) begin
        item = raw_bytes_q.pop_front();
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= item.data_byte;
        s_axis_tlast_i  <= item.end_of_stream;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct());
  end

  always @(posedge clk_i) begin
    code_beat_t exp_beat;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      code_count++;
      if (expected_code_q.size() == 0) begin
        $error("code byte %02h arrived with nothing expected", m_axis_tdata_o);
        error_count++;
      end else begin
        exp_beat = expected_code_q.pop_front();
        if (m_axis_tdata_o !== exp_beat.code_byte) begin
          $error("code_byte: expected %02h, got %02h", exp_beat.code_byte, m_axis_tdata_o);
          error_count++;
        end
        if (m_axis_tlast_o !== exp_beat.run_last) begin
          $error("run_last: expected %0b, got %0b", exp_beat.run_last, m_axis_tlast_o);
          error_count++;
        end
        if (m_axis_tuser_o !== exp_beat.stream_done) begin
          $error("stream_done: expected %0b, got %0b", exp_beat.stream_done, m_axis_tuser_o);
          error_count++;
        end
      end
    end
  end

  initial begin
    #2ms;
    $display("Timed out with %0d code bytes still outstanding.", expected_code_q.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int unsigned len;
    // Single-byte streams give the shortest code word, 12 bits, with four bits of padding.
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'h00, 1'b1);
    // Two full blocks and one byte make 136 bits, so no padding byte is needed.
    for (int i = 0; i < 7; i++) queue_byte(8'hFF, 1'b0);
    for (int i = 0; i < 7; i++) queue_byte(8'h00, 1'b0);
    queue_byte(8'h80, 1'b1);
    // The block fills on the same beat that closes the stream.
    for (int i = 0; i < 7; i++) queue_byte(8'hA5 ^ 8'(i), i == 6);

    while (total_items < NUM_ITEMS) begin
      if ($urandom_range(99) < 80) len = $urandom_range(1, 20);
      else len = $urandom_range(21, 45);
      for (int unsigned i = 0; i < len; i++) queue_byte(8'($urandom), i == len - 1);
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (raw_bytes_q.size() > 0 || s_axis_tvalid_i) @(posedge clk_i);
    while (expected_code_q.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Encoded %0d streams from %0d input bytes; %0d code bytes checked.",
             stream_count, in_count, code_count);
    if (error_count == 0 && expected_code_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
